// File: sv/s2c_pkg.sv
// ============================================================================
// s2c_pkg
// Shared types, constants and the arctangent table for the spherical to
// Cartesian converter.
// ============================================================================
package s2c_pkg;

    // angle and vector formats inside the CORDIC
    localparam int DEG_FRAC = 24;
    localparam int VEC_FRAC = 30;
    localparam int STEP_W   = 5;

    localparam logic signed [32:0] CORDIC_GAIN    = 33'sd652032874;
    localparam logic [32:0]        RAD_TO_DEG_Q24 = 33'd961263669;

    // multiplier sequence, one step per cycle
    localparam logic [STEP_W-1:0] MUL_RS_PROD = 5'd0;
    localparam logic [STEP_W-1:0] MUL_Z_PROD  = 5'd1;
    localparam logic [STEP_W-1:0] MUL_X_PROD  = 5'd2;
    localparam logic [STEP_W-1:0] MUL_Y_PROD  = 5'd3;
    localparam logic [STEP_W-1:0] MUL_Y_DONE  = 5'd4;

    typedef struct packed {
        logic              accept;
        logic              load;
        logic              rotate;
        logic              trig;
        logic              mul;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } s2c_cmd_t;

    typedef struct packed {
        logic out_free;
    } s2c_status_t;

    // atan(2^-i) in degrees, Q24
    function automatic logic signed [32:0] atan_step(input logic [STEP_W-1:0] i);
        logic [32:0] sum;
        logic [32:0] res;
        sum = RAD_TO_DEG_Q24 + (33'd1 << (i - 5'd1));
        case (i)
            5'd0:    res = 33'd754974720;
            5'd1:    res = 33'd445687602;
            5'd2:    res = 33'd235489088;
            5'd3:    res = 33'd119537938;
            5'd4:    res = 33'd60000934;
            5'd5:    res = 33'd30029717;
            5'd6:    res = 33'd15018523;
            5'd7:    res = 33'd7509720;
            5'd8:    res = 33'd3754917;
            5'd9:    res = 33'd1877466;
            default: res = sum >> i;
        endcase
        return $signed(res);
    endfunction

endpackage

// File: sv/spherical_to_cartesian.sv
// ============================================================================
// spherical_to_cartesian
// Each item passes through the accept cycle, CORDIC load, TRIG_BITS + 2
// rotations, trig rounding, five multiplier steps and the hand-off to the
// output register; the next input transfer is taken only after that hand-off.
// A result waiting in the output register does not block the next input
// transfer; a second finished result does.
// Reset: asynchronous, active low; held radius 1.0, held angles zero.
// ============================================================================
module spherical_to_cartesian #(
    parameter int ANGLE_FRAC_BITS  = 6,
    parameter int RADIUS_FRAC_BITS = 16,
    parameter int TRIG_BITS        = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // radius[31:0], polar_angle, azimuth_angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // x_coord[31:0], y_coord, z_coord
    output logic [2:0]  m_axis_tuser    // radius_ok, polar_ok, azimuth_ok
);
    import s2c_pkg::*;

    s2c_cmd_t    cmd;
    s2c_status_t status;

    s2c_ctrl #(
        .TRIG_BITS (TRIG_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    s2c_dp #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS),
        .TRIG_BITS        (TRIG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    // one item in flight: busy right after a transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready while an item is in flight");

    // a new result comes only at the end of the sequence
    a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
        else $error("result appeared outside the end of a sequence");

    // at most one command phase per cycle
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load, cmd.rotate, cmd.trig, cmd.mul, cmd.out_load}))
        else $error("overlapping controller commands");

endmodule

// File: sv/s2c_cordic.sv
// ============================================================================
// s2c_cordic
// One iterative rotation-mode CORDIC lane: quadrant split on load, one
// rotation per cycle, then rounding, clamping and quadrant mapping.
// ============================================================================
module s2c_cordic #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int TRIG_BITS       = 16,
    parameter int ANGLE_W         = 15
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         rotate,
    input  logic                         finish,
    input  logic [s2c_pkg::STEP_W-1:0]   step,
    input  logic [ANGLE_W-1:0]           angle,
    output logic signed [TRIG_BITS+1:0]  sin_val,
    output logic signed [TRIG_BITS+1:0]  cos_val
);
    import s2c_pkg::*;

    localparam int Q90   = 90 << ANGLE_FRAC_BITS;
    localparam int REM_W = $clog2(Q90);
    localparam int SH    = VEC_FRAC - TRIG_BITS;
    localparam int TW    = TRIG_BITS + 2;

    localparam logic signed [33:0] HALF_V  = 34'sd1 <<< (SH - 1);
    localparam logic signed [33:0] ONE_V   = 34'sd1 <<< TRIG_BITS;
    localparam logic signed [33:0] NONE_V  = -ONE_V;
    localparam logic signed [TW-1:0] ONE_T = TW'(ONE_V);

    logic [16:0]        angle_ext;
    logic [16:0]        sub;
    logic [1:0]         quad;
    logic [REM_W-1:0]   rem;

    logic signed [32:0] x_reg, y_reg, z_reg;
    logic [1:0]         quad_reg;
    logic               zero_reg;
    logic signed [TW-1:0] sin_reg, cos_reg;

    logic signed [32:0] dx, dy, at;
    logic signed [33:0] x_sum, y_sum, x_sh, y_sh;
    logic signed [TW-1:0] c_rnd, s_rnd, c_v, s_v, c_map, s_map;

    assign angle_ext = 17'(angle);

    // quadrant split by compares against multiples of 90 degrees
    always_comb
    begin
        if (angle_ext >= 17'(4 * Q90))
        begin
            quad = 2'd0;
            sub  = 17'(4 * Q90);
        end
        else if (angle_ext >= 17'(3 * Q90))
        begin
            quad = 2'd3;
            sub  = 17'(3 * Q90);
        end
        else if (angle_ext >= 17'(2 * Q90))
        begin
            quad = 2'd2;
            sub  = 17'(2 * Q90);
        end
        else if (angle_ext >= 17'(Q90))
        begin
            quad = 2'd1;
            sub  = 17'(Q90);
        end
        else
        begin
            quad = 2'd0;
            sub  = 17'd0;
        end
        rem = REM_W'(angle_ext - sub);
    end

    assign dx = y_reg >>> step;
    assign dy = x_reg >>> step;
    assign at = atan_step(step);

    // round half up to TRIG_BITS fraction bits, clamp to [-1, 1]
    always_comb
    begin
        x_sum = 34'(x_reg) + HALF_V;
        y_sum = 34'(y_reg) + HALF_V;
        x_sh  = x_sum >>> SH;
        y_sh  = y_sum >>> SH;
        if (x_sh > ONE_V)
            c_rnd = TW'(ONE_V);
        else if (x_sh < NONE_V)
            c_rnd = TW'(NONE_V);
        else
            c_rnd = TW'(x_sh);
        if (y_sh > ONE_V)
            s_rnd = TW'(ONE_V);
        else if (y_sh < NONE_V)
            s_rnd = TW'(NONE_V);
        else
            s_rnd = TW'(y_sh);
        // exact axis: skip the CORDIC residue
        c_v = zero_reg ? ONE_T : c_rnd;
        s_v = zero_reg ? '0 : s_rnd;
        case (quad_reg)
            2'd0:
            begin
                c_map = c_v;
                s_map = s_v;
            end
            2'd1:
            begin
                c_map = -s_v;
                s_map = c_v;
            end
            2'd2:
            begin
                c_map = -c_v;
                s_map = -s_v;
            end
            default:
            begin
                c_map = s_v;
                s_map = -c_v;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed(33'(rem) << (DEG_FRAC - ANGLE_FRAC_BITS));
            quad_reg <= quad;
            zero_reg <= (rem == '0);
        end
        else if (rotate)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
        if (finish)
        begin
            sin_reg <= s_map;
            cos_reg <= c_map;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// File: sv/s2c_dp.sv
// ============================================================================
// s2c_dp
// Datapath: range checks and held values, two CORDIC lanes, one shared
// multiplier with rounding and saturation, and the output register.
// ============================================================================
module s2c_dp #(
    parameter int ANGLE_FRAC_BITS  = 6,
    parameter int RADIUS_FRAC_BITS = 16,
    parameter int TRIG_BITS        = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  s2c_pkg::s2c_cmd_t      cmd,
    output s2c_pkg::s2c_status_t   status,
    input  logic [63:0]            in_data,
    output logic [95:0]            out_data,
    output logic [2:0]             out_user,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import s2c_pkg::*;

    localparam int POLAR_MAX = 180 << ANGLE_FRAC_BITS;
    localparam int AZIM_MAX  = 360 << ANGLE_FRAC_BITS;
    localparam int POLAR_W   = (POLAR_MAX > 32767) ? 15 : $clog2(POLAR_MAX + 1);
    localparam int AZIM_W    = (AZIM_MAX > 32767) ? 15 : $clog2(AZIM_MAX + 1);
    localparam int TW        = TRIG_BITS + 2;
    localparam int PW        = 32 + TW;

    localparam logic [30:0]          RADIUS_ONE = 31'(1) << RADIUS_FRAC_BITS;
    localparam logic signed [PW:0]   HALF_P     = (PW+1)'(1) <<< (TRIG_BITS - 1);
    localparam logic signed [PW:0]   MAX_P      = (PW+1)'(32'sh7fff_ffff);
    localparam logic signed [PW:0]   MIN_P      = (PW+1)'(32'sh8000_0000);

    logic signed [31:0] in_radius;
    logic signed [15:0] in_polar, in_azim;
    logic               r_ok, p_ok, a_ok;

    logic [30:0]          held_radius_reg;
    logic [POLAR_W-1:0]   held_polar_reg;
    logic [AZIM_W-1:0]    held_azim_reg;
    logic                 r_ok_reg, p_ok_reg, a_ok_reg;

    logic signed [TW-1:0] sp, cp, sa, ca;

    logic signed [31:0]   mul_a;
    logic signed [TW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW:0]   rsum, rsh;
    logic signed [31:0]   rnd;
    logic signed [31:0]   rs_reg, x_reg, y_reg, z_reg;

    logic [95:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        out_valid_reg;

    assign in_radius = $signed(in_data[31:0]);
    assign in_polar  = $signed(in_data[47:32]);
    assign in_azim   = $signed(in_data[63:48]);

    assign r_ok = !in_radius[31] && (in_radius != '0);
    assign p_ok = !in_polar[15] && (17'(in_polar[14:0]) <= 17'(POLAR_MAX));
    assign a_ok = !in_azim[15] && (17'(in_azim[14:0]) <= 17'(AZIM_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_radius_reg <= RADIUS_ONE;
            held_polar_reg  <= '0;
            held_azim_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            if (r_ok)
                held_radius_reg <= in_radius[30:0];
            if (p_ok)
                held_polar_reg <= in_polar[POLAR_W-1:0];
            if (a_ok)
                held_azim_reg <= in_azim[AZIM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            r_ok_reg <= r_ok;
            p_ok_reg <= p_ok;
            a_ok_reg <= a_ok;
        end
    end

    s2c_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .TRIG_BITS       (TRIG_BITS),
        .ANGLE_W         (POLAR_W)
    ) u_polar (
        .clk     (clk),
        .load    (cmd.load),
        .rotate  (cmd.rotate),
        .finish  (cmd.trig),
        .step    (cmd.step),
        .angle   (held_polar_reg),
        .sin_val (sp),
        .cos_val (cp)
    );

    s2c_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .TRIG_BITS       (TRIG_BITS),
        .ANGLE_W         (AZIM_W)
    ) u_azim (
        .clk     (clk),
        .load    (cmd.load),
        .rotate  (cmd.rotate),
        .finish  (cmd.trig),
        .step    (cmd.step),
        .angle   (held_azim_reg),
        .sin_val (sa),
        .cos_val (ca)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.step)
            MUL_RS_PROD:
            begin
                mul_a = $signed({1'b0, held_radius_reg});
                mul_b = sp;
            end
            MUL_X_PROD:
            begin
                mul_a = rs_reg;
                mul_b = ca;
            end
            MUL_Y_PROD:
            begin
                mul_a = rs_reg;
                mul_b = sa;
            end
            default:
            begin
                mul_a = $signed({1'b0, held_radius_reg});
                mul_b = cp;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // round half up back to the radius format, saturate to 32 bits
    always_comb
    begin
        rsum = (PW+1)'(prod_reg) + HALF_P;
        rsh  = rsum >>> TRIG_BITS;
        if (rsh > MAX_P)
            rnd = 32'sh7fff_ffff;
        else if (rsh < MIN_P)
            rnd = 32'sh8000_0000;
        else
            rnd = 32'(rsh);
    end

    // after the first step, each step rounds the previous product; all but the last also form the next one
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= mul_p;
            case (cmd.step)
                MUL_Z_PROD: rs_reg <= rnd;
                MUL_X_PROD: z_reg  <= rnd;
                MUL_Y_PROD: x_reg  <= rnd;
                MUL_Y_DONE: y_reg  <= rnd;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {z_reg, y_reg, x_reg};
            out_user_reg <= {a_ok_reg, p_ok_reg, r_ok_reg};
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_data        = out_data_reg;
    assign out_user        = out_user_reg;
    assign out_valid       = out_valid_reg;

endmodule

// File: sv/s2c_ctrl.sv
// ============================================================================
// s2c_ctrl
// Controller: sequences accept, CORDIC load and rotations, trig rounding,
// the multiplier steps and the hand-off to the output register.
// ============================================================================
module s2c_ctrl #(
    parameter int TRIG_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  s2c_pkg::s2c_status_t  status,
    output s2c_pkg::s2c_cmd_t     cmd
);
    import s2c_pkg::*;

    localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(TRIG_BITS + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_ROT  = 6'b000100,
        ST_TRIG = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cmd.rotate = 1'b1;
                if (step_reg == ROT_LAST)
                    state_next = ST_TRIG;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_TRIG:
            begin
                cmd.trig   = 1'b1;
                step_next  = MUL_RS_PROD;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (step_reg == MUL_Y_DONE)
                    state_next = ST_DONE;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// File: test/tb_top.sv
// ============================================================================
// tb_top
// Streaming test of the spherical to Cartesian converter. A built-in CORDIC
// predictor tracks the held radius and angles and computes x, y, z and the
// three accept flags for every input transfer. Each output transfer is checked
// field by field against the oldest prediction. Directed corner points come
// first, then random points under several input/output pacing schemes,
// including a long output hold-off.
// ============================================================================
module tb_top;

    localparam int ANGLE_FRAC   = 6;
    localparam int RADIUS_FRAC  = 16;
    localparam int TRIG_FRAC    = 16;
    localparam int CLK_PERIOD   = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_OFF_LEN = 300;
    localparam int DRAIN_CYCLES = 40;

    localparam int POLAR_MAX   = 180 << ANGLE_FRAC;
    localparam int AZIMUTH_MAX = 360 << ANGLE_FRAC;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               r_ok;
        logic               p_ok;
        logic               a_ok;
    } coord_set_t;

    class conversion_tracker;
        longint      atan_q24[10];
        logic [31:0] held_radius;
        logic [15:0] held_polar;
        logic [15:0] held_azimuth;
        coord_set_t  pending_coords[$];
        int          points_noted;
        int          results_checked;
        int          mismatches;

        function new();
            atan_q24 = '{754974720, 445687602, 235489088, 119537938, 60000934,
                         30029717, 15018523, 7509720, 3754917, 1877466};
            held_radius  = 32'd1 << RADIUS_FRAC;
            held_polar   = '0;
            held_azimuth = '0;
        endfunction

        // atan(2^-i) in degrees, 24 fraction bits
        function longint atan_deg(int i);
            if (i < 10)
                return atan_q24[i];
            return (longint'(961263669) + (longint'(1) << (i - 1))) >>> i;
        endfunction

        function longint trig_round(longint v);
            longint one;
            longint r;
            one = longint'(1) << TRIG_FRAC;
            r = (v + (longint'(1) << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
            if (r > one)
                r = one;
            if (r < -one)
                r = -one;
            return r;
        endfunction

        function void sin_cos(int angle, output longint s, output longint c);
            int     quad;
            int     rem;
            longint vx;
            longint vy;
            longint vz;
            longint dx;
            longint dy;
            longint cq;
            longint sq;
            quad = angle / (90 << ANGLE_FRAC);
            rem  = angle % (90 << ANGLE_FRAC);
            if (rem == 0)
            begin
                cq = longint'(1) << TRIG_FRAC;
                sq = 0;
            end
            else
            begin
                vx = 652032874;
                vy = 0;
                vz = longint'(rem) << (24 - ANGLE_FRAC);
                for (int i = 0; i < TRIG_FRAC + 2; i++)
                begin
                    dx = vy >>> i;
                    dy = vx >>> i;
                    if (vz >= 0)
                    begin
                        vx -= dx;
                        vy += dy;
                        vz -= atan_deg(i);
                    end
                    else
                    begin
                        vx += dx;
                        vy -= dy;
                        vz += atan_deg(i);
                    end
                end
                cq = trig_round(vx);
                sq = trig_round(vy);
            end
            case (quad & 3)
                0: begin c = cq;  s = sq;  end
                1: begin c = -sq; s = cq;  end
                2: begin c = -cq; s = -sq; end
                default: begin c = sq; s = -cq; end
            endcase
        endfunction

        function longint scale(longint v, longint t);
            return (v * t + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function coord_set_t convert_point(logic [31:0] r, logic [15:0] p,
                                           logic [15:0] a);
            coord_set_t res;
            int         ri;
            shortint    pi;
            shortint    ai;
            longint     sp;
            longint     cp;
            longint     sa;
            longint     ca;
            longint     rad;
            longint     rs;
            ri = r;
            pi = p;
            ai = a;
            res.r_ok = ri > 0;
            res.p_ok = pi >= 0 && pi <= POLAR_MAX;
            res.a_ok = ai >= 0 && ai <= AZIMUTH_MAX;
            if (res.r_ok)
                held_radius = r;
            if (res.p_ok)
                held_polar = p;
            if (res.a_ok)
                held_azimuth = a;
            sin_cos(int'(held_polar), sp, cp);
            sin_cos(int'(held_azimuth), sa, ca);
            rad = longint'(held_radius);
            rs  = scale(rad, sp);
            res.x = clip32(scale(rs, ca));
            res.y = clip32(scale(rs, sa));
            res.z = clip32(scale(rad, cp));
            return res;
        endfunction

        function void note_point(logic [31:0] r, logic [15:0] p, logic [15:0] a);
            pending_coords.push_back(convert_point(r, p, a));
            points_noted++;
        endfunction

        task report(string what, longint got, longint want);
            $display("ERROR: result %0d %s: got %0d, expected %0d",
                     results_checked, what, got, want);
            mismatches++;
        endtask

        task check_coords(logic [95:0] data, logic [2:0] flags);
            coord_set_t want;
            if (pending_coords.size() == 0)
            begin
                report("unexpected transfer", 0, 0);
                return;
            end
            want = pending_coords.pop_front();
            if ($signed(data[31:0]) !== want.x)
                report("x_coord", $signed(data[31:0]), want.x);
            if ($signed(data[63:32]) !== want.y)
                report("y_coord", $signed(data[63:32]), want.y);
            if ($signed(data[95:64]) !== want.z)
                report("z_coord", $signed(data[95:64]), want.z);
            if (flags[0] !== want.r_ok)
                report("radius_ok", flags[0], want.r_ok);
            if (flags[1] !== want.p_ok)
                report("polar_ok", flags[1], want.p_ok);
            if (flags[2] !== want.a_ok)
                report("azimuth_ok", flags[2], want.a_ok);
            results_checked++;
        endtask

        function int pending();
            return pending_coords.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // radius[31:0], polar_angle, azimuth_angle
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // x_coord[31:0], y_coord, z_coord
    logic [2:0]  m_axis_tuser;   // radius_ok, polar_ok, azimuth_ok

    int  send_idle_pct;
    int  stall_pct;
    bit  hold_off_req;

    conversion_tracker tracker;

    spherical_to_cartesian #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC),
        .RADIUS_FRAC_BITS (RADIUS_FRAC),
        .TRIG_BITS        (TRIG_FRAC)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("spherical_to_cartesian verification failed");
        $finish;
    end

    // output side: random stalls, plus an occasional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_coords(m_axis_tdata, m_axis_tuser);
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task offer_point(logic [31:0] r, logic [15:0] p, logic [15:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a, p, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_point(r, p, a);
        @(negedge clk);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    function logic [31:0] rand_radius();
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2:       return $urandom_range(2);
            default: return {1'b0, 31'($urandom())} >> $urandom_range(24);
        endcase
    endfunction

    function logic [15:0] rand_angle(int limit);
        case ($urandom_range(19))
            0, 1, 2: return 16'($urandom());
            3:       return 16'(limit - 2 + $urandom_range(4));
            4:       return 16'($urandom_range(2)) - 16'd1;
            default: return 16'($urandom_range(limit));
        endcase
    endfunction

    task random_points(int count);
        repeat (count)
            offer_point(rand_radius(), rand_angle(POLAR_MAX), rand_angle(AZIMUTH_MAX));
    endtask

    initial
    begin
        tracker       = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_req  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners: reset state, rejected values, limits, quadrant boundaries
        offer_point(32'd0, 16'hFFFF, 16'h8000);
        offer_point(32'h8000_0000, 16'(POLAR_MAX + 1), 16'(AZIMUTH_MAX + 1));
        offer_point(32'd1, 16'd0, 16'd0);
        offer_point(32'h7FFF_FFFF, 16'd5760, 16'd0);
        offer_point(32'h7FFF_FFFF, 16'd5760, 16'd5760);
        offer_point(32'h7FFF_FFFF, 16'd5760, 16'd11520);
        offer_point(32'h7FFF_FFFF, 16'd5760, 16'd17280);
        offer_point(32'h7FFF_FFFF, 16'd5760, 16'(AZIMUTH_MAX));
        offer_point(32'h0001_0000, 16'(POLAR_MAX), 16'd0);
        offer_point(32'h0001_0000, 16'h7FFF, 16'h7FFF);
        offer_point(32'hFFFF_FFFF, 16'd2880, 16'd2880);
        offer_point(32'h0064_0000, 16'd1, 16'd1);
        offer_point(32'h7FFF_FFFF, 16'd5759, 16'(AZIMUTH_MAX - 1));
        offer_point(32'd12345678, 16'(POLAR_MAX - 1), 16'd5761);
        offer_point(32'h4000_0000, 16'd3840, 16'd20000);
        offer_point(32'hFFFF_FFFB, 16'h7FFF, 16'h0000);
        offer_point(32'd300000, 16'h8000, 16'(AZIMUTH_MAX));
        offer_point(32'h7FFF_FFFF, 16'd7000, 16'd14000);
        drain();

        random_points(160);
        drain();

        send_idle_pct = 61;
        random_points(160);
        drain();

        // long hold-off on the output while inputs keep coming
        send_idle_pct = 0;
        stall_pct     = 61;
        hold_off_req  = 1'b1;
        random_points(160);
        drain();

        send_idle_pct = 6;
        stall_pct     = 6;
        random_points(160);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d points sent, %0d conversions checked, %0d mismatches",
                 tracker.points_noted, tracker.results_checked, tracker.mismatches);
        $display("covered: limits, rejects, quadrant edges; free, sparse, stalled pacing");
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("spherical_to_cartesian verification clean");
        else
            $display("spherical_to_cartesian verification failed");
        $finish;
    end

endmodule

// File: sim.f
sv/s2c_pkg.sv
sv/s2c_cordic.sv
sv/s2c_dp.sv
sv/s2c_ctrl.sv
sv/spherical_to_cartesian.sv
test/tb_top.sv
